### design/bounded_double_ended_queue_unit_defines.svh
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bdq_pkg.sv
// Package: widths, request codes, controller types for the deque.
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int REQ_W     = 3;
	localparam int CNT_W     = 5;
	localparam int APB_W     = 32;
	localparam int ADDR_W    = 3;

	// Request codes; anything else is a status request
	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_REAR  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REM_REAR  = 3'd3;

	// Register map (word index taken from paddr[2])
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load_req;
		logic exec;
		logic load_rsp;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rsp_free;
	} dpath_stat_t;

endpackage

### design/bdq_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface bdq_req_if;
	logic                              valid;
	logic                              ready;
	logic [bdq_pkg::REQ_W-1:0]         req_type;
	logic signed [bdq_pkg::DATA_W-1:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface

interface bdq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              ok;
	logic signed [bdq_pkg::DATA_W-1:0] front_value;
	logic signed [bdq_pkg::DATA_W-1:0] rear_value;
	logic                              is_empty;
	logic                              is_full;
	logic [bdq_pkg::CNT_W-1:0]         count;

	modport source (output valid, output ok, output front_value, output rear_value,
		output is_empty, output is_full, output count, input ready);
	modport sink (input valid, input ok, input front_value, input rear_value,
		input is_empty, input is_full, input count, output ready);
endinterface

### design/bounded_double_ended_queue_unit.sv
// Bounded deque: the result is registered once the request beat is accepted and has
// passed execute, memory read and response load, which run in turn, one request at a time,
// through the single entry memory and its registered read ports.
// A response waiting at the output does not block the next request beat.
// Asynchronous active-low reset: empty deque, pointers at slot 0, capacity 16;
// entry memory contents are not reset and reach the response only once written.
`timescale 1ns / 1ps

module bounded_double_ended_queue_unit #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bdq_req_if.sink                    req,
	bdq_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bdq_pkg::ADDR_W-1:0] paddr,
	input  logic [bdq_pkg::APB_W-1:0]  pwdata,
	output logic [bdq_pkg::APB_W-1:0]  prdata,
	output logic                       pready
);

	logic [bdq_pkg::CNT_W-1:0] capacity;
	bdq_pkg::ctrl_cmd_t        cmd;
	bdq_pkg::dpath_stat_t      stat;
	logic                      in_ready;

	assign req.ready = in_ready;

	bdq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bdq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_type (req.req_type),
		.value    (req.value),
		.capacity (capacity),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

### design/bdq_cfg.sv
// APB capacity register.
`timescale 1ns / 1ps

module bdq_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bdq_pkg::ADDR_W-1:0]   paddr,
	input  logic [bdq_pkg::APB_W-1:0]    pwdata,
	output logic [bdq_pkg::APB_W-1:0]    prdata,
	output logic                         pready,
	output logic [bdq_pkg::CNT_W-1:0]    capacity
);

	logic [bdq_pkg::CNT_W-1:0] capacity_q;
	logic                      wr_cap;

	assign pready = 1'b1;
	assign wr_cap = psel && penable && pwrite && (paddr[2] == bdq_pkg::REG_CAPACITY);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bdq_pkg::CAP_RESET;
		end else if (wr_cap) begin
			capacity_q <= pwdata[bdq_pkg::CNT_W-1:0];
		end
	end

	// read back
	assign prdata   = (paddr[2] == bdq_pkg::REG_CAPACITY) ?
		bdq_pkg::APB_W'(capacity_q) : '0;
	assign capacity = capacity_q;

endmodule

### design/bdq_ctrl.sv
// Sequencing FSM: accept, execute, read back, respond.
`timescale 1ns / 1ps

`include "bounded_double_ended_queue_unit_defines.svh"

module bdq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bdq_pkg::dpath_stat_t stat,
	output bdq_pkg::ctrl_cmd_t   cmd
);

	bdq_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = bdq_pkg::ST_EXEC;
				end
			end
			bdq_pkg::ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = bdq_pkg::ST_READ;
			end
			bdq_pkg::ST_READ: begin
				state_nxt = bdq_pkg::ST_RESP;
			end
			bdq_pkg::ST_RESP: begin
				if (stat.rsp_free) begin
					cmd.load_rsp = 1'b1;
					state_nxt    = bdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bdq_pkg::ST_IDLE;
			end
		endcase
	end

	`BDQ_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_q == bdq_pkg::ST_EXEC, "accepted beat did not start execution")
	`BDQ_ASSERT_NEXT(a_exec_read, cmd.exec, state_q == bdq_pkg::ST_READ, "execute not followed by read")
	`BDQ_ASSERT_NOW(a_rsp_free, cmd.load_rsp, stat.rsp_free, "response loaded into a busy output")

endmodule

### design/bdq_dpath.sv
// Datapath: ring pointers, count, entry memory and response register.
`timescale 1ns / 1ps

`include "bounded_double_ended_queue_unit_defines.svh"

module bdq_dpath #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bdq_pkg::REQ_W-1:0]         req_type,
	input  logic signed [bdq_pkg::DATA_W-1:0] value,
	input  logic [bdq_pkg::CNT_W-1:0]         capacity,
	input  bdq_pkg::ctrl_cmd_t                cmd,
	output bdq_pkg::dpath_stat_t              stat,
	bdq_rsp_if.source                         rsp
);

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = bdq_pkg::CNT_W;
	localparam int DW  = bdq_pkg::DATA_W;
	localparam int SW  = ((PW > CW) ? PW : CW) + 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CAP_MAX   = CW'((DEPTH < 31) ? DEPTH : 31);

	function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] i);
		return (i == LAST_SLOT) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [PW-1:0] slot_prev(input logic [PW-1:0] i);
		return (i == '0) ? LAST_SLOT : i - 1'b1;
	endfunction

	logic [bdq_pkg::REQ_W-1:0] req_type_q;
	logic [DW-1:0]             value_q;
	logic [PW-1:0]             head_q, tail_q;
	logic [CW-1:0]             cnt_q;
	logic                      ok_q;
	logic [DW-1:0]             mem_q [DEPTH];
	logic [DW-1:0]             rd_front_q, rd_rear_q;
	logic                      rsp_valid_q;

	logic [CW-1:0] cap_eff;
	logic          can_ins, can_rem, ok_c;
	logic [PW-1:0] head_nxt, tail_nxt, wr_addr;
	logic [CW-1:0] cnt_nxt;
	logic          wr_en;
	logic [SW-1:0] ring_sum, ring_wrap;

	// capacity saturates at the memory depth, capped at 31
	assign cap_eff = (capacity > CAP_MAX) ? CAP_MAX : capacity;
	assign can_ins = cnt_q < cap_eff;
	assign can_rem = cnt_q != '0;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req_type;
			value_q    <= value;
		end
	end

	// pointer, count and write decode
	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		cnt_nxt  = cnt_q;
		wr_addr  = tail_q;
		wr_en    = 1'b0;
		ok_c     = 1'b1;
		unique case (req_type_q)
			bdq_pkg::REQ_INS_FRONT: begin
				ok_c = can_ins;
				if (can_ins) begin
					head_nxt = slot_prev(head_q);
					wr_addr  = slot_prev(head_q);
					wr_en    = 1'b1;
					cnt_nxt  = cnt_q + 1'b1;
				end
			end
			bdq_pkg::REQ_INS_REAR: begin
				ok_c = can_ins;
				if (can_ins) begin
					tail_nxt = slot_next(tail_q);
					wr_en    = 1'b1;
					cnt_nxt  = cnt_q + 1'b1;
				end
			end
			bdq_pkg::REQ_REM_FRONT: begin
				ok_c = can_rem;
				if (can_rem) begin
					head_nxt = slot_next(head_q);
					cnt_nxt  = cnt_q - 1'b1;
				end
			end
			bdq_pkg::REQ_REM_REAR: begin
				ok_c = can_rem;
				if (can_rem) begin
					tail_nxt = slot_prev(tail_q);
					cnt_nxt  = cnt_q - 1'b1;
				end
			end
			default: begin
				ok_c = 1'b1;
			end
		endcase
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.exec) begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
			cnt_q  <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q <= ok_c;
		end
	end

	// entry memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem_q[wr_addr] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_front_q <= mem_q[head_q];
		rd_rear_q  <= mem_q[slot_prev(tail_q)];
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp.ok          <= ok_q;
			rsp.front_value <= (cnt_q == '0) ? '1 : rd_front_q;
			rsp.rear_value  <= (cnt_q == '0) ? '1 : rd_rear_q;
			rsp.is_empty    <= cnt_q == '0;
			rsp.is_full     <= cnt_q >= cap_eff;
			rsp.count       <= cnt_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign stat.rsp_free = !rsp_valid_q || rsp.ready;

	// head plus count wraps onto tail
	assign ring_sum  = SW'(head_q) + SW'(cnt_q);
	assign ring_wrap = (ring_sum >= SW'(DEPTH)) ? ring_sum - SW'(DEPTH) : ring_sum;

	`BDQ_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= CAP_MAX, "count above depth")
	`BDQ_ASSERT_NOW(a_ring, 1'b1, ring_wrap == SW'(tail_q), "head, tail and count disagree")
	`BDQ_ASSERT_NEXT(a_fail_hold, cmd.exec && !ok_c, $stable(cnt_q) && $stable(head_q) && $stable(tail_q), "failed request changed state")

endmodule
